// ===== rtl/core/ali_pkg.sv =====
// Package for the array list unit: action and status codes, field widths,
// and the command and status structs between controller and datapath.
// No dependencies.
package ali_pkg;

  localparam int ACT_W = 2;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int CNT_OUT_W = 8;
  localparam int ST_W = 2;

  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd3;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch the request and its checks
    logic rd_old;    // read the entry at the request position
    logic cap_old;   // keep the read data as the returned value
    logic rd_shift;  // read the source entry of the next move
    logic wr_shift;  // write the moved entry and step the index
    logic wr_value;  // write the request value at its slot
    logic finish;    // update the count and load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             err;
    logic             shift_done;
    logic             out_free;
  } sts_t;

endpackage

// ===== rtl/core/array_list_insert_delete_unit.sv =====
// Append and failed requests go from check straight to finish; update reads the old
// entry and writes the value; insert moves entries up and writes the value; delete
// keeps the old entry and moves entries down. Each move is one memory read and write.
// Only one item is in work; its result is loaded once the output register is free, and
// the next item is accepted after that, even while the result still waits there.
// Reset clears the count and the handshake state; the entry memory is not cleared.
module array_list_insert_delete_unit
  import ali_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position [6:0], value [38:7], zero [39]
  input  logic [1:0]  s_tuser,   // action [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // old_value [31:0], entry_count [39:32]
  output logic [1:0]  m_tuser    // status [1:0]
);

  cmd_t cmd;
  sts_t sts;

  logic [VAL_W-1:0]     old_value;
  logic [CNT_OUT_W-1:0] entry_count;

  ali_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ali_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .action      (s_tuser),
    .position    (s_tdata[6:0]),
    .value       (s_tdata[38:7]),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .old_value   (old_value),
    .entry_count (entry_count),
    .status      (m_tuser)
  );

  assign m_tdata = {entry_count, old_value};

endmodule

// ===== rtl/core/ali_ctrl.sv =====
// Controller state machine of the array list unit.
// Sequences checks, memory reads and writes and entry moves.
// Depends on ali_pkg.
module ali_ctrl
  import ali_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_CHECK      = 3'd1;
  localparam logic [2:0] S_UPD_WR     = 3'd2;
  localparam logic [2:0] S_DEL_CAP    = 3'd3;
  localparam logic [2:0] S_SHIFT_TEST = 3'd4;
  localparam logic [2:0] S_SHIFT_WR   = 3'd5;
  localparam logic [2:0] S_FINISH     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.err) begin
          state_next = S_FINISH;
        end else begin
          case (sts.action)
            ACT_APPEND: begin
              cmd.wr_value = 1'b1;
              state_next = S_FINISH;
            end
            ACT_INSERT: begin
              state_next = S_SHIFT_TEST;
            end
            ACT_DELETE: begin
              cmd.rd_old = 1'b1;
              state_next = S_DEL_CAP;
            end
            default: begin
              cmd.rd_old = 1'b1;
              state_next = S_UPD_WR;
            end
          endcase
        end
      end
      S_UPD_WR: begin
        cmd.cap_old = 1'b1;
        cmd.wr_value = 1'b1;
        state_next = S_FINISH;
      end
      S_DEL_CAP: begin
        cmd.cap_old = 1'b1;
        state_next = S_SHIFT_TEST;
      end
      S_SHIFT_TEST: begin
        if (sts.shift_done) begin
          // An insert still owes the new value at the opened slot.
          cmd.wr_value = (sts.action == ACT_INSERT);
          state_next = S_FINISH;
        end else begin
          cmd.rd_shift = 1'b1;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        state_next = S_SHIFT_TEST;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/ali_datapath.sv =====
// Datapath of the array list unit: entry memory, count, request registers,
// move index and output register.
// Depends on ali_pkg; driven by ali_ctrl commands.
module ali_datapath
  import ali_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [ACT_W-1:0]     action,
  input  logic [POS_W-1:0]     position,
  input  logic [VAL_W-1:0]     value,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [VAL_W-1:0]     old_value,
  output logic [CNT_OUT_W-1:0] entry_count,
  output logic [ST_W-1:0]      status
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata;

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_upd;
  logic [ACT_W-1:0] action_r;
  logic [AW-1:0]    pos_r;
  logic [VAL_W-1:0] value_r;
  logic [ST_W-1:0]  st_r;
  logic [VAL_W-1:0] old_r;
  logic [AW-1:0]    k;

  logic [PW-1:0]    pos_x;
  logic [PW-1:0]    cnt_x;
  logic             full;
  logic [ST_W-1:0]  st_new;

  logic             is_ins;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic             wr_en;
  logic             rd_en;

  // Request checks, made against the count at the time of acceptance.
  assign pos_x = PW'(position);
  assign cnt_x = PW'(count);
  assign full  = (count == CAP_C);

  always_comb begin
    case (action)
      ACT_APPEND: st_new = full ? ST_FULL : ST_DONE;
      ACT_INSERT: st_new = (pos_x > cnt_x) ? ST_RANGE : (full ? ST_FULL : ST_DONE);
      default:    st_new = (pos_x >= cnt_x) ? ST_RANGE : ST_DONE;
    endcase
  end

  assign is_ins = (action_r == ACT_INSERT);

  // Inserts move entries up from the top end; deletes move them down
  // starting just above the removed slot.
  assign raddr = cmd.rd_shift ? (is_ins ? AW'(k - 1'b1) : AW'(k + 1'b1)) : pos_r;
  assign waddr = cmd.wr_shift ? k : ((action_r == ACT_APPEND) ? AW'(count) : pos_r);
  assign wdata = cmd.wr_shift ? rdata : value_r;
  assign wr_en = cmd.wr_shift | cmd.wr_value;
  assign rd_en = cmd.rd_shift | cmd.rd_old;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    if (st_r != ST_DONE) begin
      count_upd = count;
    end else begin
      case (action_r)
        ACT_APPEND: count_upd = CW'(count + 1'b1);
        ACT_INSERT: count_upd = CW'(count + 1'b1);
        ACT_DELETE: count_upd = CW'(count - 1'b1);
        default:    count_upd = count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= action;
      pos_r    <= AW'(position);
      value_r  <= value;
      st_r     <= st_new;
      old_r    <= '0;
      k        <= (action == ACT_INSERT) ? AW'(count) : AW'(position);
    end else begin
      if (cmd.cap_old) begin
        old_r <= rdata;
      end
      if (cmd.wr_shift) begin
        k <= is_ins ? AW'(k - 1'b1) : AW'(k + 1'b1);
      end
    end
    if (cmd.finish) begin
      old_value   <= old_r;
      entry_count <= CNT_OUT_W'(count_upd);
      status      <= st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count    <= count_upd;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign sts.action     = action_r;
  assign sts.err        = (st_r != ST_DONE);
  assign sts.shift_done = is_ins ? (k == pos_r) : ((CW'(k) + CW'(1)) == count);
  assign sts.out_free   = !m_tvalid || m_tready;

endmodule

// ===== rtl/core/ali_checker.sv =====
// Port-level checks for the array list unit and the bind that attaches them.
// Depends on ali_pkg and array_list_insert_delete_unit.
module ali_checker
  import ali_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_DONE) |-> (m_tdata[31:0] == 32'd0))
    else $error("failed request returned a nonzero value");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_DONE) || (m_tuser == ST_FULL) || (m_tuser == ST_RANGE))
    else $error("unknown status code");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_FULL) |-> (m_tdata[39:32] == 8'(CAPACITY)))
    else $error("full status with a count below capacity");

endmodule

bind array_list_insert_delete_unit ali_checker #(
  .CAPACITY (CAPACITY)
) u_ali_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
